// ----- rtl/core/tpa_pkg.sv -----
// Shared widths, pipeline control struct and arctangent table for the
// three-point angle pipeline. No dependencies.
package tpa_pkg;

   localparam int CoordW            = 25;
   localparam int DiffW             = 26;
   localparam int ProdW             = 52;
   localparam int SumW              = 53;
   localparam int MagW              = 52;
   localparam int MsbW              = 6;
   localparam int ShiftW            = 5;
   localparam int NormW             = 30;
   localparam int NormTop           = 29;
   localparam int SqW               = 60;
   localparam int RadW              = 62;
   localparam int RemW              = 63;
   localparam int RootW             = 31;
   localparam int IsqrtSteps        = 32;
   localparam int XyW               = 36;
   localparam int AngW              = 42;
   localparam int AtanW             = 38;
   localparam int AccFrac           = 32;
   localparam int AngleW            = 24;
   localparam int TabLen            = 32;
   localparam int NumCoords         = 9;
   localparam int ReqDataW          = 232;
   localparam int DefAngleFracBits  = 16;
   localparam int DefCordicSteps    = 20;

   typedef struct packed {
      logic vld;
      logic degen;
      logic neg;
   } tpa_ctl_type;

   // atan(2^-i) in degrees, 32 fraction bits
   localparam logic [AtanW-1:0] ATAN_TAB [TabLen] = '{
      38'd193273528320, 38'd114096026022, 38'd60285206654, 38'd30601712201,
      38'd15360239196,  38'd7687607525,   38'd3844741810,  38'd1922488225,
      38'd961258780,    38'd480631223,    38'd240315841,   38'd120157949,
      38'd60078978,     38'd30039490,     38'd15019745,    38'd7509872,
      38'd3754936,      38'd1877468,      38'd938734,      38'd469367,
      38'd234684,       38'd117342,       38'd58671,       38'd29335,
      38'd14668,        38'd7334,         38'd3667,        38'd1833,
      38'd917,          38'd458,          38'd229,         38'd115
   };

   function automatic logic [MsbW-1:0] msb_index(input logic [MagW-1:0] w);
      logic [MsbW-1:0] idx;
      idx = '0;
      for (int i = 0; i < MagW; i++) begin
         if (w[i]) idx = MsbW'(i);
      end
      return idx;
   endfunction

endpackage

// ----- rtl/core/tpa_products.sv -----
// Front of the angle pipeline: arm vectors, products, dot and cross sums,
// magnitudes. Depends on tpa_pkg.
module tpa_products import tpa_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_vld,
   input  logic [NumCoords-1:0][CoordW-1:0] pts,
   output tpa_ctl_type                     ctl_out,
   output logic [MagW-1:0]                 mag [4]
);

   // stage 1: arm vectors u = A - B, v = C - B
   tpa_ctl_type             s1_ctl_ff, s1_ctl_in;
   logic signed [DiffW-1:0] u_ff [3], v_ff [3], u_in [3], v_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = DiffW'(signed'(pts[k]))     - DiffW'(signed'(pts[3 + k]));
         v_in[k] = DiffW'(signed'(pts[6 + k])) - DiffW'(signed'(pts[3 + k]));
      end
      s1_ctl_in.vld   = in_vld;
      s1_ctl_in.degen = (u_in[0] == '0 && u_in[1] == '0 && u_in[2] == '0) ||
                        (v_in[0] == '0 && v_in[1] == '0 && v_in[2] == '0);
      s1_ctl_in.neg   = 1'b0;
   end

   // stage 2: nine products
   tpa_ctl_type             s2_ctl_ff;
   logic signed [ProdW-1:0] p_ff [9];

   // stage 3: dot and cross sums
   tpa_ctl_type             s3_ctl_ff;
   logic signed [SumW-1:0]  dot_ff, cr_ff [3];

   // stage 4: magnitudes
   tpa_ctl_type             s4_ctl_ff, s4_ctl_in;
   logic [MagW-1:0]         mag_ff [4];

   always_comb begin
      s4_ctl_in     = s3_ctl_ff;
      s4_ctl_in.neg = dot_ff[SumW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s4_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= u_in;
         v_ff <= v_in;
         p_ff[0] <= u_ff[0] * v_ff[0];
         p_ff[1] <= u_ff[1] * v_ff[1];
         p_ff[2] <= u_ff[2] * v_ff[2];
         p_ff[3] <= u_ff[1] * v_ff[2];
         p_ff[4] <= u_ff[2] * v_ff[1];
         p_ff[5] <= u_ff[2] * v_ff[0];
         p_ff[6] <= u_ff[0] * v_ff[2];
         p_ff[7] <= u_ff[0] * v_ff[1];
         p_ff[8] <= u_ff[1] * v_ff[0];
         dot_ff   <= SumW'(p_ff[0]) + SumW'(p_ff[1]) + SumW'(p_ff[2]);
         cr_ff[0] <= SumW'(p_ff[3]) - SumW'(p_ff[4]);
         cr_ff[1] <= SumW'(p_ff[5]) - SumW'(p_ff[6]);
         cr_ff[2] <= SumW'(p_ff[7]) - SumW'(p_ff[8]);
         mag_ff[0] <= MagW'(dot_ff[SumW-1] ? -dot_ff : dot_ff);
         for (int k = 0; k < 3; k++) begin
            mag_ff[k + 1] <= MagW'(cr_ff[k][SumW-1] ? -cr_ff[k] : cr_ff[k]);
         end
      end
   end

   assign ctl_out = s4_ctl_ff;
   assign mag     = mag_ff;

endmodule

// ----- rtl/core/tpa_norm.sv -----
// Common normalization of the four magnitudes so the largest lands in
// [2^29, 2^30). Depends on tpa_pkg.
module tpa_norm import tpa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  tpa_ctl_type      ctl_in,
   input  logic [MagW-1:0]  mag [4],
   output tpa_ctl_type      ctl_out,
   output logic [NormW-1:0] q [4]
);

   tpa_ctl_type       s1_ctl_ff, s2_ctl_ff;
   logic [MagW-1:0]   mag_ff [4];
   logic [ShiftW-1:0] rs_ff, ls_ff, rs_in, ls_in;
   logic [NormW-1:0]  q_ff [4];
   logic [MsbW-1:0]   top;

   // the largest magnitude shares its leading bit with the OR of all four
   always_comb begin
      top = msb_index(mag[0] | mag[1] | mag[2] | mag[3]);
      if (top >= MsbW'(NormTop)) begin
         rs_in = ShiftW'(top - MsbW'(NormTop));
         ls_in = '0;
      end else begin
         rs_in = '0;
         ls_in = ShiftW'(MsbW'(NormTop) - top);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag;
         rs_ff  <= rs_in;
         ls_ff  <= ls_in;
         for (int k = 0; k < 4; k++) begin
            q_ff[k] <= NormW'((mag_ff[k] >> rs_ff) << ls_ff);
         end
      end
   end

   assign ctl_out = s2_ctl_ff;
   assign q       = q_ff;

endmodule

// ----- rtl/core/tpa_isqrt.sv -----
// Cross-product length: squares, sum, then a one-bit-per-stage integer
// square root. Depends on tpa_pkg.
module tpa_isqrt import tpa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  tpa_ctl_type      ctl_in,
   input  logic [NormW-1:0] q [4],
   output tpa_ctl_type      ctl_out,
   output logic [NormW-1:0] q0_out,
   output logic [RootW-1:0] root
);

   tpa_ctl_type      sq_ctl_ff;
   logic [SqW-1:0]   sq_ff [3];
   logic [NormW-1:0] sq_q0_ff;

   tpa_ctl_type      ctl_ff [IsqrtSteps+1];
   logic [NormW-1:0] q0_ff  [IsqrtSteps+1];
   logic [RemW-1:0]  n_ff   [IsqrtSteps+1];
   logic [RemW-1:0]  r_ff   [IsqrtSteps+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl_ff <= '0;
         ctl_ff[0] <= '0;
      end else if (en) begin
         sq_ctl_ff <= ctl_in;
         ctl_ff[0] <= sq_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= SqW'(q[k + 1]) * SqW'(q[k + 1]);
         end
         sq_q0_ff <= q[0];
         n_ff[0]  <= RemW'(RadW'(sq_ff[0]) + RadW'(sq_ff[1]) + RadW'(sq_ff[2]));
         r_ff[0]  <= '0;
         q0_ff[0] <= sq_q0_ff;
      end
   end

   for (genvar s = 0; s < IsqrtSteps; s++) begin : g_root
      localparam logic [RemW-1:0] Bit = RemW'(1) << (2 * (IsqrtSteps - 1 - s));
      logic [RemW-1:0] trial;
      assign trial = r_ff[s] + Bit;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s + 1] <= '0;
         end else if (en) begin
            ctl_ff[s + 1] <= ctl_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q0_ff[s + 1] <= q0_ff[s];
            if (n_ff[s] >= trial) begin
               n_ff[s + 1] <= n_ff[s] - trial;
               r_ff[s + 1] <= (r_ff[s] >> 1) + Bit;
            end else begin
               n_ff[s + 1] <= n_ff[s];
               r_ff[s + 1] <= r_ff[s] >> 1;
            end
         end
      end
   end

   assign ctl_out = ctl_ff[IsqrtSteps];
   assign q0_out  = q0_ff[IsqrtSteps];
   assign root    = RootW'(r_ff[IsqrtSteps]);

endmodule

// ----- rtl/core/tpa_cordic.sv -----
// Vectoring CORDIC atan2(|u x v|, u.v) in degrees, one step per stage,
// then clamp, round and the output register. Depends on tpa_pkg.
module tpa_cordic import tpa_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = DefAngleFracBits,
   parameter int CORDIC_STEPS    = DefCordicSteps
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  tpa_ctl_type       ctl_in,
   input  logic [NormW-1:0]  q0,
   input  logic [RootW-1:0]  root,
   output tpa_ctl_type       ctl_out,
   output logic [AngleW-1:0] angle,
   output logic              degen
);

   localparam int Sh = AccFrac - ANGLE_FRAC_BITS;
   localparam logic [AngW-1:0] Half  = AngW'(1) << (Sh - 1);
   localparam logic [AngW-1:0] Lim   = AngW'(180) << ANGLE_FRAC_BITS;
   localparam logic [AngW-1:0] Max24 = AngW'({AngleW{1'b1}});
   localparam logic [AngW-1:0] Quarter = AngW'(90) << AccFrac;

   tpa_ctl_type             ctl_ff [CORDIC_STEPS+1];
   logic signed [XyW-1:0]   x_ff   [CORDIC_STEPS+1];
   logic signed [XyW-1:0]   y_ff   [CORDIC_STEPS+1];
   logic signed [AngW-1:0]  z_ff   [CORDIC_STEPS+1];

   // pre-rotation: an obtuse angle starts from 90 degrees
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (ctl_in.neg) begin
            x_ff[0] <= XyW'(root);
            y_ff[0] <= XyW'(q0);
            z_ff[0] <= Quarter;
         end else begin
            x_ff[0] <= XyW'(q0);
            y_ff[0] <= XyW'(root);
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [XyW-1:0]  xs, ys;
      logic signed [AngW-1:0] t;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign t  = AngW'(ATAN_TAB[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i + 1] <= '0;
         end else if (en) begin
            ctl_ff[i + 1] <= ctl_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[i][XyW-1]) begin
               x_ff[i + 1] <= x_ff[i] + ys;
               y_ff[i + 1] <= y_ff[i] - xs;
               z_ff[i + 1] <= z_ff[i] + t;
            end else begin
               x_ff[i + 1] <= x_ff[i] - ys;
               y_ff[i + 1] <= y_ff[i] + xs;
               z_ff[i + 1] <= z_ff[i] - t;
            end
         end
      end
   end

   // clamp below zero, round half up, saturate
   logic signed [AngW-1:0] zf;
   logic [AngW-1:0]        zc, rnd, sat;
   tpa_ctl_type            out_ctl_ff;
   logic [AngleW-1:0]      angle_ff, angle_in;

   always_comb begin
      zf  = z_ff[CORDIC_STEPS];
      zc  = zf[AngW-1] ? '0 : zf;
      rnd = (zc + Half) >> Sh;
      sat = (rnd > Lim) ? Lim : rnd;
      if (sat > Max24) sat = Max24;
      angle_in = ctl_ff[CORDIC_STEPS].degen ? '0 : AngleW'(sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else if (en) begin
         out_ctl_ff <= ctl_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign ctl_out = out_ctl_ff;
   assign angle   = angle_ff;
   assign degen   = out_ctl_ff.degen;

endmodule

// ----- rtl/core/three_point_angle.sv -----
// Top level of the three-point angle pipeline: angle at vertex B of A, B, C.
// Depends on tpa_pkg, tpa_products, tpa_norm, tpa_isqrt and tpa_cordic.
//
// Usage: one request beat carries the nine coordinates of A, B and C
// (25-bit signed, thousandths of an angstrom). One response beat returns
// the angle at B in degrees scaled by 2^ANGLE_FRAC_BITS and a flag that
// marks a zero-length arm (angle then reads zero).
// Stages from request accept to response valid: four product/sum stages,
// two normalization stages, two square/sum stages, 32 square-root stages
// (one root bit each), the pre-rotation, one stage per CORDIC step and
// the output register.
// Throughput (no stall): one beat per cycle; every stage is a register
// with its own valid bit, so a new request can enter every cycle.
// Stall: while the response register holds a beat that is not taken, the
// whole pipeline freezes and req_tready drops; nothing is lost or repeated.
// Bubbles move along with their valid bits.
// Reset: synchronous, active high, clears all valid bits; data registers
// are not reset. No state is kept between beats.
module three_point_angle import tpa_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = DefAngleFracBits,
   parameter int CORDIC_STEPS    = DefCordicSteps
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z,
   // point_c_x, point_c_y, point_c_z (25 bits each), zero pad to 232
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // angle_deg (24 bits)
   output logic [AngleW-1:0]   rsp_tdata,
   // degenerate (1 bit)
   output logic                rsp_tuser
);

   logic en;

   tpa_ctl_type      prod_ctl, norm_ctl, root_ctl, out_ctl;
   logic [MagW-1:0]  mag [4];
   logic [NormW-1:0] q [4];
   logic [NormW-1:0] q0;
   logic [RootW-1:0] root;
   logic [NumCoords-1:0][CoordW-1:0] pts;

   // advance every stage unless the response beat is stuck
   assign en         = !(out_ctl.vld && !rsp_tready);
   assign req_tready = en;
   assign rsp_tvalid = out_ctl.vld;
   assign pts        = req_tdata[NumCoords*CoordW-1:0];

   tpa_products u_products (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .pts     (pts),
      .ctl_out (prod_ctl),
      .mag     (mag)
   );

   tpa_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (prod_ctl),
      .mag     (mag),
      .ctl_out (norm_ctl),
      .q       (q)
   );

   tpa_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (norm_ctl),
      .q       (q),
      .ctl_out (root_ctl),
      .q0_out  (q0),
      .root    (root)
   );

   tpa_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (root_ctl),
      .q0      (q0),
      .root    (root),
      .ctl_out (out_ctl),
      .angle   (rsp_tdata),
      .degen   (rsp_tuser)
   );

endmodule
